// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define LLS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("linear fit check failed");

// check that also holds while reset is applied
`define LLS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("linear fit reset check failed");

`endif

// ===== hdl/lls_pkg.sv =====
package lls_pkg;

	localparam int MaxPoints = 65536;
	localparam int FracBits = 16;
	localparam int CountW = 17;
	localparam int WideW = 82;
	localparam int NumW = 66;
	localparam int DenW = 65;
	localparam int DivSteps = WideW;
	localparam int StepW = 7;
	localparam int MulChunks = 3;

	typedef struct packed {
		logic signed [15:0] x_value;
		logic signed [15:0] y_value;
		logic               has_point;
		logic               last_item;
	} in_word_t;

	typedef struct packed {
		logic signed [47:0] slope_fixed;
		logic signed [47:0] intercept_fixed;
		logic               degenerate;
		logic               empty_set;
		logic               points_dropped;
	} out_word_t;

	typedef enum logic [2:0] {
		MS_N_SXY,
		MS_SX_SY,
		MS_N_SXX,
		MS_SX_SX,
		MS_SLOPE_SX
	} mul_sel_t;

	typedef struct packed {
		logic       accum;
		logic       init;
		logic       mul_load;
		logic       mul_step;
		logic [1:0] chunk;
		logic       store;
		mul_sel_t   sel;
		logic       set_degen;
		logic       div_load_slope;
		logic       div_step;
		logic       div_take;
		logic       take_icpt;
		logic       publish;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic den_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hdl/lls_datapath.sv =====
module lls_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lls_pkg::in_word_t   point,
	input  lls_pkg::dp_cmd_t    cmd,
	output lls_pkg::dp_status_t status,
	output logic                fit_valid,
	input  logic                fit_stall,
	output lls_pkg::out_word_t  fit
);

	localparam int WW = lls_pkg::WideW;

	logic [lls_pkg::CountW-1:0] n_q;
	logic signed [31:0] sx_q, sy_q;
	logic signed [47:0] sxy_q, sxx_q;
	logic               ovf_q;

	logic [47:0]            ma_q;
	logic [32:0]            mb_q;
	logic                   mneg_q;
	logic [80:0]            macc_q;
	logic signed [WW-1:0]   t_q;
	logic signed [lls_pkg::NumW-1:0] num_q;
	logic signed [lls_pkg::DenW-1:0] den_q;

	logic [WW-1:0] dv_q;
	logic [63:0]   dd_q;
	logic [63:0]   rem_q;
	logic          qneg_q;

	logic signed [47:0] slope_q, icpt_q;
	logic               degen_q;
	lls_pkg::out_word_t fit_q;
	logic               fit_valid_q;

	logic signed [31:0] xy_prod, xx_prod;
	logic signed [47:0] mul_a;
	logic signed [32:0] mul_b;
	logic [48:0]        pp;
	logic signed [WW-1:0] prod;
	logic signed [WW-1:0] diff;
	logic signed [WW-1:0] icpt_num;
	logic signed [WW-1:0] slope_num;
	logic [63:0]          den_mag;
	logic [64:0]          trial;
	logic [64:0]          trial_sub;
	logic [WW-1:0]        limit;
	logic [47:0]          q_sat;
	logic signed [47:0]   q_res;

	assign xy_prod = point.x_value * point.y_value;
	assign xx_prod = point.x_value * point.x_value;

	always_comb begin
		case (cmd.sel)
			lls_pkg::MS_N_SXY: begin
				mul_a = sxy_q;
				mul_b = 33'(n_q);
			end
			lls_pkg::MS_SX_SY: begin
				mul_a = 48'(sy_q);
				mul_b = 33'(sx_q);
			end
			lls_pkg::MS_N_SXX: begin
				mul_a = sxx_q;
				mul_b = 33'(n_q);
			end
			lls_pkg::MS_SX_SX: begin
				mul_a = 48'(sx_q);
				mul_b = 33'(sx_q);
			end
			lls_pkg::MS_SLOPE_SX: begin
				mul_a = slope_q;
				mul_b = 33'(sx_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign pp   = ma_q[16*cmd.chunk +: 16] * mb_q;
	assign prod = mneg_q ? -$signed({1'b0, macc_q}) : $signed({1'b0, macc_q});
	assign diff = t_q - prod;
	assign icpt_num  = (WW'(sy_q) <<< lls_pkg::FracBits) - prod;
	assign slope_num = WW'(num_q) <<< lls_pkg::FracBits;
	assign den_mag   = den_q[lls_pkg::DenW-1] ? 64'(-den_q) : 64'(den_q);

	// one restoring step: bring down the next dividend bit
	assign trial     = {rem_q, dv_q[WW-1]};
	assign trial_sub = trial - {1'b0, dd_q};

	assign limit = qneg_q ? WW'(48'h8000_0000_0000) : WW'(48'h7FFF_FFFF_FFFF);
	assign q_sat = (dv_q > limit) ? limit[47:0] : dv_q[47:0];
	assign q_res = qneg_q ? -$signed(q_sat) : $signed(q_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
			ovf_q <= 1'b0;
			fit_valid_q <= 1'b0;
		end else begin
			if (fit_valid_q && !fit_stall) begin
				fit_valid_q <= 1'b0;
			end
			if (cmd.accum && point.has_point) begin
				if (n_q < lls_pkg::CountW'(lls_pkg::MaxPoints)) begin
					n_q   <= n_q + 1'b1;
					sx_q  <= sx_q + 32'(point.x_value);
					sy_q  <= sy_q + 32'(point.y_value);
					sxy_q <= sxy_q + 48'(xy_prod);
					sxx_q <= sxx_q + 48'(xx_prod);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.publish) begin
				fit_valid_q <= 1'b1;
				n_q   <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
				sxy_q <= '0;
				sxx_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			slope_q <= '0;
			icpt_q  <= '0;
			degen_q <= 1'b0;
		end
		if (cmd.set_degen) begin
			degen_q <= 1'b1;
		end
		if (cmd.mul_load) begin
			ma_q   <= mul_a[47] ? 48'(-mul_a) : 48'(mul_a);
			mb_q   <= mul_b[32] ? 33'(-mul_b) : 33'(mul_b);
			mneg_q <= mul_a[47] ^ mul_b[32];
			macc_q <= '0;
		end
		if (cmd.mul_step) begin
			macc_q <= macc_q + (81'(pp) << (16 * cmd.chunk));
		end
		if (cmd.store) begin
			case (cmd.sel)
				lls_pkg::MS_N_SXY, lls_pkg::MS_N_SXX: t_q <= prod;
				lls_pkg::MS_SX_SY: num_q <= diff[lls_pkg::NumW-1:0];
				lls_pkg::MS_SX_SX: den_q <= diff[lls_pkg::DenW-1:0];
				lls_pkg::MS_SLOPE_SX: begin
					dv_q   <= icpt_num[WW-1] ? WW'(-icpt_num) : WW'(icpt_num);
					dd_q   <= 64'(n_q);
					rem_q  <= '0;
					qneg_q <= icpt_num[WW-1];
				end
				default: t_q <= t_q;
			endcase
		end
		if (cmd.div_load_slope) begin
			dv_q   <= slope_num[WW-1] ? WW'(-slope_num) : WW'(slope_num);
			dd_q   <= den_mag;
			rem_q  <= '0;
			qneg_q <= slope_num[WW-1] ^ den_q[lls_pkg::DenW-1];
		end
		if (cmd.div_step) begin
			if (trial >= {1'b0, dd_q}) begin
				rem_q <= trial_sub[63:0];
				dv_q  <= {dv_q[WW-2:0], 1'b1};
			end else begin
				rem_q <= trial[63:0];
				dv_q  <= {dv_q[WW-2:0], 1'b0};
			end
		end
		if (cmd.div_take) begin
			if (cmd.take_icpt) begin
				icpt_q <= q_res;
			end else begin
				slope_q <= q_res;
			end
		end
		if (cmd.publish) begin
			fit_q.slope_fixed     <= slope_q;
			fit_q.intercept_fixed <= icpt_q;
			fit_q.degenerate      <= degen_q;
			fit_q.empty_set       <= (n_q == '0);
			fit_q.points_dropped  <= ovf_q;
		end
	end

	assign status.n_zero   = (n_q == '0);
	assign status.den_zero = (den_q == '0);
	assign status.out_free = !fit_valid_q || !fit_stall;
	assign fit_valid = fit_valid_q;
	assign fit       = fit_q;

endmodule

// ===== hdl/lls_control.sv =====
module lls_control (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                point_valid,
	input  logic                last_item,
	output logic                point_stall,
	input  lls_pkg::dp_status_t status,
	output lls_pkg::dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MLOAD,
		S_MSTEP,
		S_MSTORE,
		S_DENCHK,
		S_DIV,
		S_DTAKE,
		S_FINISH
	} state_t;

	state_t               state_q;
	logic [lls_pkg::StepW-1:0] cnt_q;
	lls_pkg::mul_sel_t    sel_q;
	logic                 icpt_q;

	assign point_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		cmd.chunk = cnt_q[1:0];
		cmd.take_icpt = icpt_q;
		case (state_q)
			S_IDLE:   cmd.accum = point_valid;
			S_CHECK:  cmd.init = 1'b1;
			S_MLOAD:  cmd.mul_load = 1'b1;
			S_MSTEP:  cmd.mul_step = 1'b1;
			S_MSTORE: cmd.store = 1'b1;
			S_DENCHK: begin
				cmd.set_degen      = status.den_zero;
				cmd.div_load_slope = !status.den_zero;
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_DTAKE:  cmd.div_take = 1'b1;
			S_FINISH: cmd.publish = status.out_free;
			default:  cmd.accum = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= lls_pkg::MS_N_SXY;
			icpt_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (point_valid && last_item) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					sel_q  <= lls_pkg::MS_N_SXY;
					icpt_q <= 1'b0;
					state_q <= status.n_zero ? S_FINISH : S_MLOAD;
				end
				S_MLOAD: begin
					cnt_q   <= '0;
					state_q <= S_MSTEP;
				end
				S_MSTEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lls_pkg::StepW'(lls_pkg::MulChunks - 1)) begin
						state_q <= S_MSTORE;
					end
				end
				S_MSTORE: begin
					cnt_q <= '0;
					case (sel_q)
						lls_pkg::MS_SX_SX: state_q <= S_DENCHK;
						lls_pkg::MS_SLOPE_SX: begin
							icpt_q  <= 1'b1;
							state_q <= S_DIV;
						end
						default: begin
							sel_q   <= lls_pkg::mul_sel_t'(sel_q + 1'b1);
							state_q <= S_MLOAD;
						end
					endcase
				end
				S_DENCHK: begin
					cnt_q <= '0;
					if (status.den_zero) begin
						// slope stays zero, go straight to the intercept product
						sel_q   <= lls_pkg::MS_SLOPE_SX;
						state_q <= S_MLOAD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lls_pkg::StepW'(lls_pkg::DivSteps - 1)) begin
						state_q <= S_DTAKE;
					end
				end
				S_DTAKE: begin
					if (icpt_q) begin
						state_q <= S_FINISH;
					end else begin
						sel_q   <= lls_pkg::MS_SLOPE_SX;
						state_q <= S_MLOAD;
					end
				end
				S_FINISH: begin
					// hold until the output register is free
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/linear_least_squares_fit.sv =====
// Streaming least-squares line fit.
// Input channel point/point_valid/point_stall carries one word per item: an
// optional (x, y) point and a last mark. Output channel fit/fit_valid/fit_stall
// carries one word per set: slope and intercept in signed Q32.16, saturated to
// 48 bits, with degenerate, empty and dropped-point flags.
// Items without the last mark are taken one per cycle while no fit runs; each
// point updates the count and sums through one 16x16 multiply-accumulate stage.
// An item with the last mark starts the fit: five products on a 16x33 shared
// multiplier and two 82-step restoring divisions (only one division when the
// denominator is zero, none of either for an empty set). point_stall stays high
// until the fit is published.
// The result sits in an output register; if fit_stall holds it, the next set
// still accumulates, and only the following fit waits for the register.
// Points past 65536 in one set are ignored and flagged.
// arst_n clears all sums, the sequencer and fit_valid at once.
module linear_least_squares_fit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               point_valid,
	output logic               point_stall,
	input  lls_pkg::in_word_t  point,
	output logic               fit_valid,
	input  logic               fit_stall,
	output lls_pkg::out_word_t fit
);

	lls_pkg::dp_cmd_t    cmd;
	lls_pkg::dp_status_t status;

	lls_control u_control (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.last_item   (point.last_item),
		.point_stall (point_stall),
		.status      (status),
		.cmd         (cmd)
	);

	lls_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.point     (point),
		.cmd       (cmd),
		.status    (status),
		.fit_valid (fit_valid),
		.fit_stall (fit_stall),
		.fit       (fit)
	);

endmodule

// ===== hdl/lls_checker.sv =====
`include "assert_macros.svh"

module lls_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               point_valid,
	input logic               point_stall,
	input lls_pkg::in_word_t  point,
	input logic               fit_valid,
	input logic               fit_stall,
	input lls_pkg::out_word_t fit
);

	`LLS_ASSERT(a_fit_held, clk, arst_n, fit_valid && fit_stall |=> fit_valid && $stable(fit))
	`LLS_ASSERT(a_last_stalls, clk, arst_n, point_valid && !point_stall && point.last_item |=> point_stall)
	`LLS_ASSERT(a_empty_zero, clk, arst_n, fit_valid && fit.empty_set |-> fit.slope_fixed == '0 && fit.intercept_fixed == '0 && !fit.degenerate)
	`LLS_ASSERT(a_degen_flat, clk, arst_n, fit_valid && fit.degenerate |-> fit.slope_fixed == '0 && !fit.empty_set)
	`LLS_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !fit_valid)

endmodule

bind linear_least_squares_fit lls_checker u_lls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.point_valid (point_valid),
	.point_stall (point_stall),
	.point       (point),
	.fit_valid   (fit_valid),
	.fit_stall   (fit_stall),
	.fit         (fit)
);
